// File: design/esup_pkg.sv
package esup_pkg;

    localparam int unsigned TIMER_W   = 16;
    localparam int unsigned START_W   = 15;
    localparam int unsigned LENGTH_W  = 14;
    localparam int unsigned FREQ_W    = 10;
    localparam int unsigned PADDR_W   = 4;
    localparam int unsigned PDATA_W   = 32;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    localparam logic [2:0]         MASK_RESET    = 3'd1;
    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [TIMER_W-1:0] PERIOD_RESET  = 16'd923;

    localparam logic [FREQ_W-1:0] TONE_HIGH_HZ = 10'(392 * 2);
    localparam logic [FREQ_W-1:0] TONE_LOW_HZ  = 10'(349 * 2);

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_REFRESH = 2'd1,
        MODE_HOST_VS = 2'd2,
        MODE_CFG_VS  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        LED_NONE   = 2'd0,
        LED_RED    = 2'd1,
        LED_GREEN  = 2'd2,
        LED_PURPLE = 2'd3
    } led_t;

    typedef enum logic [1:0] {
        REG_MASK    = 2'd0,
        REG_TIMEOUT = 2'd1,
        REG_PERIOD  = 2'd2,
        REG_NONE    = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        WORD_STATUS = 2'd0,
        WORD_TONE_A = 2'd1,
        WORD_TONE_B = 2'd2,
        WORD_TONE_C = 2'd3
    } word_idx_t;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_TONE   = 1'b1
    } kind_t;

    typedef struct packed {
        logic stopped;
        logic notify;
        logic notify_value;
        led_t led;
        logic buzzer_clear;
        logic alarm;
    } result_t;

endpackage

// File: design/emergency_stop_supervisor_core.sv
// Emergency-stop supervisor.
// Input channel (in_valid/in_stall) carries one word per tick or host event:
// mode, three switch levels and the virtual switch value. Output channel
// (out_valid/out_stall) returns one status word per input, followed by three
// alarm tone words when a tick fires the alarm; last marks the final word.
// Registers are set through the APB port at 0x0 (switch mask), 0x4 (link
// timeout) and 0x8 (alarm period); writes are to be made while the block is
// idle, which the block does not enforce. Stop state and timers update in
// the cycle a word is accepted. A new input word is taken every cycle while
// the output is free; an alarm tick holds the output for its four words and
// one more input waits in a pending register, after which in_stall rises.
// Reset leaves the block stopped with the virtual switch clear, both timers
// at zero and the registers at their defaults. While the receiver stalls,
// the output word holds and at most one further input word is accepted.
module emergency_stop_supervisor_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [esup_pkg::PADDR_W-1:0]  paddr,
    input  logic [esup_pkg::PDATA_W-1:0]  pwdata,
    output logic [esup_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    mode,
    input  logic                          switch_one,
    input  logic                          switch_two,
    input  logic                          switch_three,
    input  logic                          virtual_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          kind,
    output logic                          relay_closed,
    output logic                          stopped,
    output logic                          notify,
    output logic                          notify_value,
    output logic [1:0]                    led_color,
    output logic                          buzzer_clear,
    output logic [esup_pkg::START_W-1:0]  tone_start_ms,
    output logic [esup_pkg::LENGTH_W-1:0] tone_length_ms,
    output logic [esup_pkg::FREQ_W-1:0]   tone_freq_hz,
    output logic                          last
);
    import esup_pkg::*;

    logic [2:0]         mask_reg;
    logic [TIMER_W-1:0] timeout_reg;
    logic [TIMER_W-1:0] period_reg;

    logic               stop_reg, stop_next;
    logic               vswitch_reg, vswitch_next;
    logic [TIMER_W-1:0] link_reg, link_next;
    logic [TIMER_W-1:0] alarm_reg, alarm_next;

    logic               pend_valid_reg, pend_valid_next;
    result_t            pend_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;
    word_idx_t          idx_reg, idx_next;

    result_t            res;
    reg_idx_t           widx;
    logic               cfg_write;
    logic               in_fire, out_fire, out_last, out_free;
    logic [TIMER_W-1:0] link_aged, alarm_aged;
    logic [2:0]         sw;
    logic               want, link_lost;
    mode_t              mode_c;

    // configuration
    assign pready    = 1'b1;
    assign widx      = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= MASK_RESET;
            timeout_reg <= TIMEOUT_RESET;
            period_reg  <= PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (widx)
                REG_MASK:    mask_reg    <= pwdata[2:0];
                REG_TIMEOUT: timeout_reg <= pwdata[TIMER_W-1:0];
                REG_PERIOD:  period_reg  <= pwdata[TIMER_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_MASK:    prdata = {29'd0, mask_reg};
            REG_TIMEOUT: prdata = {16'd0, timeout_reg};
            REG_PERIOD:  prdata = {16'd0, period_reg};
            default:     prdata = '0;
        endcase
    end

    // handshake
    assign in_stall = pend_valid_reg;
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign out_last = (idx_reg == WORD_TONE_C) || (idx_reg == WORD_STATUS && !out_reg.alarm);
    assign out_free = !out_valid_reg || (out_fire && out_last);

    // supervisor step
    assign mode_c     = mode_t'(mode);
    assign sw         = {switch_three, switch_two, switch_one};
    assign link_aged  = (link_reg  == TIMER_MAX) ? TIMER_MAX : link_reg + 1'b1;
    assign alarm_aged = (alarm_reg == TIMER_MAX) ? TIMER_MAX : alarm_reg + 1'b1;
    assign link_lost  = link_aged > timeout_reg;
    assign want       = ((sw & mask_reg) != 3'd0) || vswitch_reg || link_lost;

    always_comb
    begin
        stop_next    = stop_reg;
        vswitch_next = vswitch_reg;
        link_next    = link_reg;
        alarm_next   = alarm_reg;
        res          = '0;
        res.led      = LED_NONE;
        case (mode_c)
            MODE_TICK:
            begin
                link_next  = link_aged;
                alarm_next = alarm_aged;
                stop_next  = want;
                if (link_lost)
                    res.led = LED_PURPLE;
                if (!stop_reg && want)
                begin
                    res.led          = LED_RED;
                    res.notify       = 1'b1;
                    res.notify_value = stop_reg;
                end
                else if (stop_reg && !want)
                begin
                    res.led          = LED_GREEN;
                    res.notify       = 1'b1;
                    res.notify_value = stop_reg;
                    res.buzzer_clear = 1'b1;
                end
                if (want && alarm_aged > period_reg)
                begin
                    res.alarm  = 1'b1;
                    alarm_next = '0;
                end
            end
            MODE_REFRESH:
                link_next = '0;
            MODE_HOST_VS:
            begin
                vswitch_next = virtual_value;
                link_next    = '0;
            end
            default:
                vswitch_next = virtual_value;
        endcase
        res.stopped = stop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg    <= 1'b1;
            vswitch_reg <= 1'b0;
            link_reg    <= '0;
            alarm_reg   <= '0;
        end
        else if (in_fire)
        begin
            stop_reg    <= stop_next;
            vswitch_reg <= vswitch_next;
            link_reg    <= link_next;
            alarm_reg   <= alarm_next;
        end
    end

    // pending and output stages
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        idx_next        = idx_reg;
        if (out_fire && !out_last)
            idx_next = word_idx_t'(idx_reg + 2'd1);
        if (out_free)
        begin
            idx_next = WORD_STATUS;
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = pend_reg;
                pend_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                out_valid_next = 1'b1;
                out_next       = res;
            end
            else
                out_valid_next = 1'b0;
        end
        else if (in_fire)
            pend_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= WORD_STATUS;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && !out_free)
            pend_reg <= res;
        out_reg <= out_next;
    end

    // output word
    always_comb
    begin
        out_valid      = out_valid_reg;
        relay_closed   = !out_reg.stopped;
        stopped        = out_reg.stopped;
        last           = out_last;
        kind           = KIND_TONE;
        notify         = 1'b0;
        notify_value   = 1'b0;
        led_color      = LED_NONE;
        buzzer_clear   = 1'b0;
        tone_length_ms = period_reg[TIMER_W-1:2];
        tone_start_ms  = '0;
        tone_freq_hz   = TONE_HIGH_HZ;
        case (idx_reg)
            WORD_STATUS:
            begin
                kind           = KIND_STATUS;
                notify         = out_reg.notify;
                notify_value   = out_reg.notify_value;
                led_color      = out_reg.led;
                buzzer_clear   = out_reg.buzzer_clear;
                tone_length_ms = '0;
                tone_freq_hz   = '0;
            end
            WORD_TONE_A:
                tone_start_ms = '0;
            WORD_TONE_B:
            begin
                tone_start_ms = {1'b0, period_reg[TIMER_W-1:2]};
                tone_freq_hz  = TONE_LOW_HZ;
            end
            default:
                tone_start_ms = period_reg[TIMER_W-1:1];
        endcase
    end

endmodule
